// ===== hdl/shb_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 block hasher.
package shb_pkg;

	// Block geometry and round count.
	localparam int SHB_WORDS_PER_BLOCK = 16;
	localparam int SHB_ROUNDS = 64;
	localparam int SHB_DIGEST_WORDS = 8;

	// Standard initial hash value, word 0 in the lowest slot.
	localparam logic [7:0][31:0] SHB_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// One input item.
	typedef struct packed {
		logic [31:0] message_word;
		logic        last_word;
	} shb_in_t;

	// One result item.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        digest_last;
	} shb_out_t;

	// Work handed from the collector to the compression engine.
	typedef struct packed {
		logic [15:0][31:0] block;
		logic              compress;
		logic              emit;
	} shb_job_t;

	// Rotate right by a constant amount.
	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// Message schedule sigma functions.
	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// Compression round Sigma functions.
	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	// Round constants.
	function automatic logic [31:0] round_k(input logic [5:0] t);
		case (t)
			6'd0: round_k = 32'h428a2f98;
			6'd1: round_k = 32'h71374491;
			6'd2: round_k = 32'hb5c0fbcf;
			6'd3: round_k = 32'he9b5dba5;
			6'd4: round_k = 32'h3956c25b;
			6'd5: round_k = 32'h59f111f1;
			6'd6: round_k = 32'h923f82a4;
			6'd7: round_k = 32'hab1c5ed5;
			6'd8: round_k = 32'hd807aa98;
			6'd9: round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h0;
		endcase
	endfunction

endpackage

// ===== hdl/shb_front.sv =====
// Word collector: gathers message words into blocks and classifies the work.
module shb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  shb_pkg::shb_in_t  msg,
	output logic              job_push,
	input  logic              job_full,
	output shb_pkg::shb_job_t job
);

	logic [3:0]        cnt_q;
	logic [14:0][31:0] buf_q;
	logic              accept;
	logic              blk_done;

	// An item is taken whenever the job queue has room.
	assign full = job_full;
	assign accept = push & ~job_full;
	assign blk_done = (cnt_q == 4'(shb_pkg::SHB_WORDS_PER_BLOCK - 1));

	// A completed block or a last word becomes a job for the engine.
	always_comb begin
		for (int i = 0; i < shb_pkg::SHB_WORDS_PER_BLOCK - 1; i++) begin
			job.block[i] = buf_q[i];
		end
		job.block[shb_pkg::SHB_WORDS_PER_BLOCK - 1] = msg.message_word;
		job.compress = blk_done;
		job.emit = msg.last_word;
		job_push = accept & (blk_done | msg.last_word);
	end

	// Word count; a last word drops any partial block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (blk_done || msg.last_word) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	// Collect buffer; the final word of a block goes straight into the job.
	always_ff @(posedge clk) begin
		if (accept && !blk_done) begin
			buf_q[cnt_q] <= msg.message_word;
		end
	end

endmodule

// ===== hdl/shb_job_queue.sv =====
// Two-entry queue of block jobs between the collector and the engine.
module shb_job_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  shb_pkg::shb_job_t wr_job,
	input  logic              pop,
	output logic              empty,
	output shb_pkg::shb_job_t rd_job
);

	shb_pkg::shb_job_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign rd_job = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ===== hdl/shb_back.sv =====
// Compression engine: runs the 64 rounds per block and emits the digest.
module shb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_empty,
	output logic              job_pop,
	input  shb_pkg::shb_job_t job,
	input  logic              res_full,
	output logic              res_push,
	output shb_pkg::shb_out_t res_item
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic [5:0]        rnd_q;
	logic [2:0]        idx_q;
	logic              emit_q;
	logic [7:0][31:0]  chain_q;
	logic [7:0][31:0]  v_q;
	logic [15:0][31:0] w_q;
	logic [31:0]       t1;
	logic [31:0]       t2;
	logic [31:0]       w_new;

	// Handshakes towards both queues.
	assign job_pop = (state_q == ST_IDLE) & ~job_empty;
	assign res_push = (state_q == ST_EMIT) & ~res_full;

	// Digest word selected by the emit counter.
	always_comb begin
		res_item.digest_word = chain_q[idx_q];
		res_item.digest_index = idx_q;
		res_item.digest_last = (idx_q == 3'(shb_pkg::SHB_DIGEST_WORDS - 1));
	end

	// Round function and schedule expansion.
	always_comb begin
		t1 = v_q[7] + shb_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ shb_pkg::round_k(rnd_q) + w_q[0];
		t2 = shb_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = w_q[0] + shb_pkg::ssig0(w_q[1]) + w_q[9] + shb_pkg::ssig1(w_q[14]);
	end

	// Sequencer and chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
			emit_q <= 1'b0;
			chain_q <= shb_pkg::SHB_IV;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						rnd_q <= '0;
						idx_q <= '0;
						emit_q <= job.emit;
						if (job.compress) begin
							state_q <= ST_ROUND;
						end else if (job.emit) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(shb_pkg::SHB_ROUNDS - 1)) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					state_q <= emit_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (res_push) begin
						idx_q <= idx_q + 3'd1;
						if (res_item.digest_last) begin
							chain_q <= shb_pkg::SHB_IV;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working variables and the sliding schedule window.
	always_ff @(posedge clk) begin
		if (job_pop && job.compress) begin
			v_q <= chain_q;
			w_q <= job.block;
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
	end

`ifndef SYNTHESIS
	// The last round always hands over to the final addition.
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'(shb_pkg::SHB_ROUNDS - 1)) |=> (state_q == ST_FINAL))
		else $error("round sequence did not end in the final addition");

	// Digest items are only produced while emitting.
	a_push_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (state_q == ST_EMIT))
		else $error("digest item pushed outside the emit phase");

	// The last digest word returns the engine to idle with a fresh chaining value.
	a_chain_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_item.digest_last) |=> (state_q == ST_IDLE && chain_q == shb_pkg::SHB_IV))
		else $error("chaining value not restored after the digest");

	// Jobs are taken only when the engine is free.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> (state_q == ST_IDLE && !job_empty))
		else $error("job taken while the engine was busy");
`endif

endmodule

// ===== hdl/shb_result_queue.sv =====
// Two-entry queue holding digest items until the receiver takes them.
module shb_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  shb_pkg::shb_out_t wr_item,
	input  logic              pop,
	output logic              empty,
	output shb_pkg::shb_out_t rd_item
);

	shb_pkg::shb_out_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign rd_item = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== hdl/sha256_block_hasher_unit.sv =====
// Top level of the SHA-256 block hasher: collector, job queue, engine, result queue.
//
// Usage: padded message words enter on msg with push; an item is taken at a
// clock edge with push high and full low. Every sixteen words form a block;
// a word with last_word set ends the message, and any partial block is dropped.
// Digest items leave on digest, oldest first, while empty is low, and one is
// taken at each edge with pop high.
// The collector takes one word per cycle while the job queue has room, and
// hands a finished block to a two-entry job queue. The engine takes a
// block only while idle: it loads the block, runs the rounds one round per
// cycle, then adds into the chaining value, and only then takes the next
// block. A last word that completes a block is compressed this way before
// its digest is emitted; one that only ends a partial block sends the engine
// straight to emitting. The eight digest words then follow one per cycle
// while the result queue has room.
// A stalled receiver fills the two-entry result queue and holds the engine,
// which then fills the job queue and raises full. Reset empties both queues
// and restores the standard initial hash value.
module sha256_block_hasher_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  shb_pkg::shb_in_t  msg,
	input  logic              pop,
	output logic              empty,
	output shb_pkg::shb_out_t digest
);

	logic              job_push;
	logic              job_full;
	logic              job_pop;
	logic              job_empty;
	shb_pkg::shb_job_t job_wr;
	shb_pkg::shb_job_t job_rd;
	logic              res_push;
	logic              res_full;
	shb_pkg::shb_out_t res_item;

	// Front: word collection and classification.
	shb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.msg      (msg),
		.job_push (job_push),
		.job_full (job_full),
		.job      (job_wr)
	);

	// Queue decoupling the collector from the engine.
	shb_job_queue u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.full   (job_full),
		.wr_job (job_wr),
		.pop    (job_pop),
		.empty  (job_empty),
		.rd_job (job_rd)
	);

	// Back: compression rounds and digest emission.
	shb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job       (job_rd),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_item  (res_item)
	);

	// Output queue towards the receiver.
	shb_result_queue u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.full    (res_full),
		.wr_item (res_item),
		.pop     (pop),
		.empty   (empty),
		.rd_item (digest)
	);

endmodule
